// ===== rtl/idal_pkg.sv =====
`default_nettype none

package idal_pkg;

    // Number of identifiers handed out; ids run from 1 to MAX_IDS.
    localparam int MAX_IDS = 256;

    // Width of an id, of the stack depth and of the live count.
    localparam int ID_W = 9;

    // Address width of the free stack memory.
    localparam int STACK_AW = $clog2(MAX_IDS);

    localparam int STATUS_W = 3;

    localparam logic [ID_W-1:0] MAX_ID = ID_W'(MAX_IDS);

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd4;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [ID_W-1:0] push_id;
    } stack_cmd_t;

    typedef struct packed {
        logic            nonempty;
        logic [ID_W-1:0] tos;
    } stack_stat_t;

    typedef struct packed {
        logic [ID_W-1:0]     assigned_id;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     live_count;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/idal_if.sv =====
`default_nettype none

interface idal_req_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [idal_pkg::ID_W-1:0]   freed_id;

    modport source (output valid, output mode, output freed_id, input ready);
    modport sink   (input valid, input mode, input freed_id, output ready);
endinterface

interface idal_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [idal_pkg::ID_W-1:0]     assigned_id;
    logic [idal_pkg::STATUS_W-1:0] status;
    logic [idal_pkg::ID_W-1:0]     live_count;

    modport source (output valid, output assigned_id, output status, output live_count,
                    input ready);
    modport sink   (input valid, input assigned_id, input status, input live_count,
                    output ready);
endinterface

interface idal_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/id_allocator_free_stack.sv =====
// Channel  Role    Handshake      Payload
// req      sink    valid/ready    mode, freed_id
// rsp      source  valid/ready    assigned_id, status, live_count
// cfg      sink    valid/ready    data (enable)
//
// One request is taken per cycle while req.ready is high; its result comes from
// the output register. The free stack keeps its top two entries in registers,
// so pops and pushes run every cycle despite the registered memory read.
// Reset clears the live marks, counters and stack depth at once; no sweep.
// A stalled result parks in a skid slot; req.ready drops only while it is full.
`default_nettype none

module id_allocator_free_stack (
    input  wire logic clk,
    input  wire logic rst_n,
    idal_req_if.sink  req,
    idal_rsp_if.source rsp,
    idal_cfg_if.sink  cfg
);

    idal_pkg::stack_cmd_t  stack_cmd;
    idal_pkg::stack_stat_t stack_stat;
    idal_pkg::rsp_t        result;
    idal_pkg::rsp_t        rsp_data;
    logic                  req_ready;
    logic                  req_fire;

    assign req.ready = req_ready;
    assign req_fire  = req.valid && req_ready;
    assign cfg.ready = 1'b1;

    idal_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (req_fire),
        .mode       (req.mode),
        .freed_id   (req.freed_id),
        .cfg_write  (cfg.valid),
        .cfg_data   (cfg.data),
        .stack_stat (stack_stat),
        .stack_cmd  (stack_cmd),
        .rsp        (result)
    );

    idal_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stack_cmd),
        .stat  (stack_stat)
    );

    idal_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req_ready),
        .in_data   (result),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp_data)
    );

    assign rsp.assigned_id = rsp_data.assigned_id;
    assign rsp.status      = rsp_data.status;
    assign rsp.live_count  = rsp_data.live_count;

endmodule

`default_nettype wire

// ===== rtl/idal_stack.sv =====
`default_nettype none

module idal_stack (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire idal_pkg::stack_cmd_t  cmd,
    output idal_pkg::stack_stat_t      stat
);

    localparam int ID_W = idal_pkg::ID_W;
    localparam int AW   = idal_pkg::STACK_AW;

    // The top entry lives in tos_reg and the one below it in nos_reg, so a pop
    // never waits on the memory. The memory holds entries 0 .. top-2.
    logic [ID_W-1:0] mem [idal_pkg::MAX_IDS];

    logic [ID_W-1:0] top_reg;
    logic [ID_W-1:0] top_next;
    logic [ID_W-1:0] tos_reg;
    logic [ID_W-1:0] tos_next;
    logic [ID_W-1:0] nos_reg;
    logic [ID_W-1:0] waddr_full;
    logic [ID_W-1:0] raddr_full;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    logic            we;

    always_comb
    begin
        top_next = top_reg;
        tos_next = tos_reg;
        if (cmd.push)
        begin
            top_next = top_reg + ID_W'(1);
            tos_next = cmd.push_id;
        end
        else if (cmd.pop)
        begin
            top_next = top_reg - ID_W'(1);
            tos_next = nos_reg;
        end
    end

    assign we         = cmd.push && (top_reg != '0);
    assign waddr_full = top_reg - ID_W'(1);
    assign waddr      = waddr_full[AW-1:0];
    // Below-top entry after this beat; its value is unused while the stack
    // holds fewer than two entries.
    assign raddr_full = top_next - ID_W'(2);
    assign raddr      = raddr_full[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (we)
        begin
            mem[waddr] <= tos_reg;
        end
        // On a push the entry just written is the new below-top entry.
        if (we && (waddr == raddr))
        begin
            nos_reg <= tos_reg;
        end
        else
        begin
            nos_reg <= mem[raddr];
        end
    end

    assign stat.nonempty = (top_reg != '0);
    assign stat.tos      = tos_reg;

endmodule

`default_nettype wire

// ===== rtl/idal_ctrl.sv =====
`default_nettype none

module idal_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic                          mode,
    input  wire logic [idal_pkg::ID_W-1:0]     freed_id,
    input  wire logic                          cfg_write,
    input  wire logic                          cfg_data,
    input  wire idal_pkg::stack_stat_t         stack_stat,
    output idal_pkg::stack_cmd_t               stack_cmd,
    output idal_pkg::rsp_t                     rsp
);

    localparam int ID_W = idal_pkg::ID_W;

    logic                       enable_reg;
    logic [ID_W-1:0]            high_water_reg;
    logic [ID_W-1:0]            high_water_next;
    logic [idal_pkg::MAX_IDS:0] live_mark_reg;
    logic [idal_pkg::MAX_IDS:0] live_mark_next;
    logic [ID_W-1:0]            live_total_reg;
    logic [ID_W-1:0]            live_total_next;
    logic                       id_in_range;
    logic                       id_live;

    assign id_in_range = (freed_id <= idal_pkg::MAX_ID);
    assign id_live     = id_in_range && live_mark_reg[freed_id];

    always_comb
    begin
        high_water_next   = high_water_reg;
        live_mark_next    = live_mark_reg;
        live_total_next   = live_total_reg;
        stack_cmd.push    = 1'b0;
        stack_cmd.pop     = 1'b0;
        stack_cmd.push_id = freed_id;
        rsp.assigned_id   = '0;
        rsp.status        = idal_pkg::ST_OK;

        if (!enable_reg)
        begin
            rsp.status = idal_pkg::ST_DISABLED;
        end
        else if (mode == idal_pkg::MODE_ALLOC)
        begin
            priority if (stack_stat.nonempty)
            begin
                stack_cmd.pop   = fire;
                rsp.assigned_id = stack_stat.tos;
            end
            else if (high_water_reg >= idal_pkg::MAX_ID)
            begin
                rsp.status = idal_pkg::ST_OVERFLOW;
            end
            else
            begin
                high_water_next = high_water_reg + ID_W'(1);
                rsp.assigned_id = high_water_next;
            end
            // Ids popped or freshly minted are never live, so the mark is set
            // and the total grows on every successful allocate.
            if (rsp.status == idal_pkg::ST_OK)
            begin
                live_mark_next[rsp.assigned_id] = 1'b1;
                live_total_next                 = live_total_reg + ID_W'(1);
            end
        end
        else
        begin
            priority if (freed_id == '0)
            begin
                rsp.status = idal_pkg::ST_ZERO;
            end
            else if (!id_live)
            begin
                rsp.status = idal_pkg::ST_UNKNOWN;
            end
            else
            begin
                live_mark_next[freed_id] = 1'b0;
                live_total_next          = live_total_reg - ID_W'(1);
                stack_cmd.push           = fire;
            end
        end

        rsp.live_count = live_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            high_water_reg <= '0;
            live_mark_reg  <= '0;
            live_total_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                enable_reg <= cfg_data;
            end
            if (fire)
            begin
                high_water_reg <= high_water_next;
                live_mark_reg  <= live_mark_next;
                live_total_reg <= live_total_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/idal_skid.sv =====
`default_nettype none

module idal_skid (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire idal_pkg::rsp_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output idal_pkg::rsp_t       out_data
);

    logic           main_valid_reg;
    logic           main_valid_next;
    idal_pkg::rsp_t main_reg;
    idal_pkg::rsp_t main_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    idal_pkg::rsp_t skid_reg;
    idal_pkg::rsp_t skid_next;
    logic           in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_ready || !main_valid_reg)
        begin
            priority if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            // The output is stalled, so the new beat waits in the skid slot.
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

`default_nettype wire

// ===== rtl/idal_checker.sv =====
`default_nettype none

module idal_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rsp_valid,
    input  wire logic                          rsp_ready,
    input  wire logic [idal_pkg::ID_W-1:0]     assigned_id,
    input  wire logic [idal_pkg::STATUS_W-1:0] status,
    input  wire logic [idal_pkg::ID_W-1:0]     live_count
);

    logic                      seen_reg;
    logic [idal_pkg::ID_W-1:0] prev_live_reg;
    logic                      rsp_beat;

    assign rsp_beat = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            prev_live_reg <= '0;
        end
        else if (rsp_beat)
        begin
            seen_reg      <= 1'b1;
            prev_live_reg <= live_count;
        end
    end

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(assigned_id)
            && $stable(status) && $stable(live_count))
        else $error("result changed while stalled");

    a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != idal_pkg::ST_OK) |-> assigned_id == '0)
        else $error("failed request handed out an id");

    // Overflow means every id is live and none waits on the free stack.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == idal_pkg::ST_OVERFLOW) |-> live_count == idal_pkg::MAX_ID)
        else $error("overflow reported with ids still available");

    a_live_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_beat && seen_reg |->
            (live_count == prev_live_reg)
            || ((status == idal_pkg::ST_OK) && (live_count == prev_live_reg + 9'd1))
            || ((status == idal_pkg::ST_OK) && (prev_live_reg == live_count + 9'd1)))
        else $error("live count moved by more than one or on a failed request");

endmodule

bind id_allocator_free_stack idal_checker u_idal_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .assigned_id (rsp.assigned_id),
    .status      (rsp.status),
    .live_count  (rsp.live_count)
);

`default_nettype wire
